/* rtl/rafvg_pkg.sv */
// ----------------------------------------------------------------------------
// rafvg_pkg
// Shared types, constants and constant tables of the ring and fan vector
// generator: CORDIC arctangent table, inverse gain and command structures.
// ----------------------------------------------------------------------------
package rafvg_pkg;

    localparam int MAX_SHOTS_DEF    = 32;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int RESULT_LIMIT = 32;
    localparam int TABLE_LEN    = 24;
    localparam int STEP_IDX_W   = 5;
    localparam int WORK_FRAC    = 24;

    // CORDIC datapath: 17-bit operands with 24 fraction bits, gain and sign.
    localparam int DP_W = 44;
    // Angle accumulator in 2^32 units per turn, one guard bit.
    localparam int Z_W  = 33;

    localparam int COUNT_W    = 6;
    localparam int SHOT_W     = 5;
    localparam int VEL_W      = 17;
    localparam int SPEED_W    = 16;
    localparam int COORD_W    = 16;
    localparam int IN_ANGLE_W = 16;
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 40;

    localparam int     VEL_LIMIT    = 65535;
    localparam longint INV_GAIN_Q31 = 64'd1304065748;

    typedef enum logic {
        MODE_ROTATE = 1'b0,
        MODE_VECTOR = 1'b1
    } cordic_mode_t;

    typedef struct packed {
        logic                   start;
        cordic_mode_t           mode;
        logic signed [DP_W-1:0] x;
        logic signed [DP_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_cmd_t;

    typedef struct packed {
        logic                   done;
        logic signed [DP_W-1:0] x;
        logic signed [DP_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_res_t;

    // atan(2^-i) in units of 2^32 per turn.
    function automatic logic [31:0] atan_turn32(input logic [STEP_IDX_W-1:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

    function automatic int clamp_steps(input int steps);
        int n;
        n = steps;
        if (n > TABLE_LEN)
        begin
            n = TABLE_LEN;
        end
        if (n < 1)
        begin
            n = 1;
        end
        return n;
    endfunction

    // Inverse CORDIC gain in Q31 with a small correction for the step count.
    function automatic longint inv_gain_for(input int steps);
        longint g;
        int     n;
        g = INV_GAIN_Q31;
        n = clamp_steps(steps);
        return g + (g >>> (2 * n - 1)) / 3;
    endfunction

endpackage

/* rtl/rafvg_cordic.sv */
// ----------------------------------------------------------------------------
// rafvg_cordic
// Shared iterative CORDIC unit, one micro-rotation per clock, in either
// rotation mode (polar to rectangular) or vectoring mode (arctangent).
// ----------------------------------------------------------------------------
module rafvg_cordic #(
    parameter int STEPS = rafvg_pkg::CORDIC_STEPS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rafvg_pkg::cordic_cmd_t  cmd,
    output rafvg_pkg::cordic_res_t  res
);
    import rafvg_pkg::*;

    localparam logic [STEP_IDX_W-1:0] LAST_STEP = STEP_IDX_W'(clamp_steps(STEPS) - 1);

    logic signed [DP_W-1:0]  x_reg, x_next;
    logic signed [DP_W-1:0]  y_reg, y_next;
    logic signed [Z_W-1:0]   z_reg, z_next;
    logic [STEP_IDX_W-1:0]   step_reg, step_next;
    cordic_mode_t            mode_reg, mode_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;

    logic signed [DP_W-1:0]  xs;
    logic signed [DP_W-1:0]  ys;
    logic signed [Z_W-1:0]   angle;
    logic                    ccw;
    logic                    hold;

    always_comb
    begin
        xs    = x_reg >>> step_reg;
        ys    = y_reg >>> step_reg;
        angle = signed'({1'b0, atan_turn32(step_reg)});
        // Rotation turns towards z = 0; vectoring turns y towards zero and
        // leaves x, y and z alone once y is exactly zero.
        if (mode_reg == MODE_ROTATE)
        begin
            ccw  = !z_reg[Z_W-1];
            hold = 1'b0;
        end
        else
        begin
            ccw  = y_reg[DP_W-1];
            hold = (y_reg == '0);
        end

        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        mode_next = mode_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (cmd.start)
        begin
            x_next    = cmd.x;
            y_next    = cmd.y;
            z_next    = cmd.z;
            mode_next = cmd.mode;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!hold)
            begin
                if (ccw)
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - angle;
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + angle;
                end
            end
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            mode_reg <= MODE_ROTATE;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign res.done = done_reg;
    assign res.x    = x_reg;
    assign res.y    = y_reg;
    assign res.z    = z_reg;

endmodule

/* rtl/rafvg_divider.sv */
// ----------------------------------------------------------------------------
// rafvg_divider
// Restoring unsigned divider, one quotient bit per clock, used to place each
// vector of a burst evenly across the ring or the fan.
// ----------------------------------------------------------------------------
module rafvg_divider #(
    parameter int DVD_W = rafvg_pkg::ANGLE_BITS_DEF + rafvg_pkg::SHOT_W,
    parameter int DVS_W = rafvg_pkg::COUNT_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    import rafvg_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_LAST;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The dividend shifts out at the top while quotient bits enter below.
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/ring_and_fan_vector_generator.sv */
// ----------------------------------------------------------------------------
// ring_and_fan_vector_generator
// Turns one request into a burst of equal-magnitude velocity vectors, spaced
// round a full ring or spread across a fan aimed from a source at a target.
// ----------------------------------------------------------------------------
// One request beat gives up to 32 result beats, the last one marked by tlast;
// a count of zero gives none. The block takes a new request only once every
// vector of the current burst has been handed to the output register. All the
// arithmetic runs through one CORDIC unit and one restoring divider, so the
// time is set by those two loops: a fan request first finds the aim
// direction with a vectoring pass, the first vector then takes a rotation
// pass, and every further vector a placement division and a rotation pass
// (one quotient bit of the placement division and one micro-rotation per
// clock). A burst also waits whenever the consumer does not take a beat.
// ----------------------------------------------------------------------------
module ring_and_fan_vector_generator #(
    parameter int MAX_SHOTS    = rafvg_pkg::MAX_SHOTS_DEF,
    parameter int ANGLE_BITS   = rafvg_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = rafvg_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // shot_count[7:0], first_angle[23:8], shot_speed[39:24], source_x[55:40],
    // source_y[71:56], aim_x[87:72], aim_y[103:88], arc_width[119:104]
    input  logic [rafvg_pkg::IN_DATA_W-1:0]  s_tdata,
    // func[0]
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // vel_x[16:0], vel_y[33:17], shot_number[38:34], zero pad[39]
    output logic [rafvg_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                             m_tlast
);
    import rafvg_pkg::*;

    localparam int AB      = ANGLE_BITS;
    localparam int CAP     = (MAX_SHOTS < RESULT_LIMIT) ? MAX_SHOTS : RESULT_LIMIT;
    localparam int NUM_W   = AB + SHOT_W;
    localparam int SHIFT_S = 32 - AB;

    localparam logic [31:0]          KQ       = 32'(inv_gain_for(CORDIC_STEPS));
    localparam logic [7:0]           CAP_8    = 8'(CAP);
    localparam logic [COUNT_W-1:0]   CAP_C    = COUNT_W'(CAP);
    localparam logic [NUM_W-1:0]     RING_INC = NUM_W'(1) << AB;
    localparam logic signed [Z_W-1:0] QUARTER = 33'sh040000000;
    localparam logic signed [Z_W-1:0] HALF    = 33'sh080000000;
    localparam logic [32:0]          ANG_RND  = 33'd1 << (SHIFT_S - 1);
    localparam logic signed [DP_W-1:0] VEL_RND = DP_W'(1) <<< (WORK_FRAC - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SETUP = 7'b0000010,
        S_VEC   = 7'b0000100,
        S_BASE  = 7'b0001000,
        S_ROT   = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_DIV   = 7'b1000000
    } state_t;

    // Rounded, saturated and optionally mirrored velocity component.
    function automatic logic [VEL_W-1:0] sat_vel(input logic signed [DP_W-1:0] v,
                                                 input logic neg);
        logic signed [DP_W-1:0] r;
        logic signed [VEL_W-1:0] s;
        r = (v + VEL_RND) >>> WORK_FRAC;
        if (r > DP_W'(VEL_LIMIT))
        begin
            s = VEL_W'(VEL_LIMIT);
        end
        else if (r < -DP_W'(VEL_LIMIT))
        begin
            s = -VEL_W'(VEL_LIMIT);
        end
        else
        begin
            s = r[VEL_W-1:0];
        end
        return neg ? -s : s;
    endfunction

    // Input fields.
    logic [7:0]           shot_count;
    logic [SPEED_W-1:0]   shot_speed;
    logic [IN_ANGLE_W-1:0] first_angle;
    logic [IN_ANGLE_W-1:0] arc_width;
    logic [COORD_W-1:0]   source_x, source_y, aim_x, aim_y;
    logic [AB-1:0]        first_ang_in;
    logic [AB-1:0]        arc_in;
    logic [COUNT_W-1:0]   count_in;

    assign shot_count  = s_tdata[7:0];
    assign first_angle = s_tdata[23:8];
    assign shot_speed  = s_tdata[39:24];
    assign source_x    = s_tdata[55:40];
    assign source_y    = s_tdata[71:56];
    assign aim_x       = s_tdata[87:72];
    assign aim_y       = s_tdata[103:88];
    assign arc_width   = s_tdata[119:104];

    generate
        if (AB >= IN_ANGLE_W)
        begin : g_widen
            assign first_ang_in = AB'(first_angle) << (AB - IN_ANGLE_W);
            assign arc_in       = AB'(arc_width) << (AB - IN_ANGLE_W);
        end
        else
        begin : g_narrow
            assign first_ang_in = AB'(first_angle >> (IN_ANGLE_W - AB));
            assign arc_in       = AB'(arc_width >> (IN_ANGLE_W - AB));
        end
    endgenerate

    assign count_in = (shot_count > CAP_8) ? CAP_C : shot_count[COUNT_W-1:0];

    state_t                 state_reg, state_next;
    logic                   func_reg, func_next;
    logic [COUNT_W-1:0]     n_reg, n_next;
    logic [COUNT_W-1:0]     dvs_reg, dvs_next;
    logic [SHOT_W-1:0]      idx_reg, idx_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic [AB-1:0]          base_reg, base_next;
    logic [AB-1:0]          arc_reg, arc_next;
    logic [SPEED_W-1:0]     speed_reg, speed_next;
    logic signed [COORD_W:0] dx_reg, dx_next;
    logic signed [COORD_W:0] dy_reg, dy_next;
    logic signed [DP_W-1:0] gain_reg, gain_next;
    logic                   neg_reg, neg_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VEL_W-1:0]       vel_x_reg, vel_x_next;
    logic [VEL_W-1:0]       vel_y_reg, vel_y_next;
    logic [SHOT_W-1:0]      shot_out_reg, shot_out_next;
    logic                   last_out_reg, last_out_next;

    cordic_cmd_t            cmd;
    cordic_res_t            res;
    logic                   div_start;
    logic [NUM_W-1:0]       dividend;
    logic                   div_done;
    logic [NUM_W-1:0]       quotient;

    logic [SPEED_W+31:0]    gain_prod;
    logic [AB-1:0]          rot_angle;
    logic [31:0]            rot_zu;
    logic signed [Z_W-1:0]  rot_z;
    logic signed [Z_W-1:0]  rot_zf;
    logic                   rot_neg;
    logic [32:0]            dir_rnd;
    logic [AB-1:0]          centre;
    logic [NUM_W-1:0]       num_sum;
    logic [NUM_W-1:0]       incr;
    logic                   out_free;
    logic                   is_last;
    logic signed [COORD_W:0] vx17, vy17;
    logic                   dx_neg;

    rafvg_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .res   (res)
    );

    rafvg_divider #(
        .DVD_W (NUM_W),
        .DVS_W (COUNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        gain_prod = speed_reg * KQ;
        out_free  = !out_valid_reg || m_tready;
        is_last   = ({1'b0, idx_reg} == (n_reg - 1'b1));
        incr      = func_reg ? NUM_W'(arc_reg) : RING_INC;
        num_sum   = num_reg + incr;
        dividend  = num_sum + NUM_W'(dvs_reg >> 1);

        // Direction from the vectoring result, rounded to the angle width.
        dir_rnd = {1'b0, res.z[31:0]} + ANG_RND;
        centre  = dir_rnd[31:SHIFT_S];

        // Fold the rotation angle into the right half plane.
        rot_angle = (state_reg == S_DIV) ? (base_reg + quotient[AB-1:0]) : base_reg;
        rot_zu    = 32'(rot_angle) << SHIFT_S;
        rot_z     = signed'({rot_zu[31], rot_zu});
        if (rot_z > QUARTER)
        begin
            rot_zf  = rot_z - HALF;
            rot_neg = 1'b1;
        end
        else if (rot_z < -QUARTER)
        begin
            rot_zf  = rot_z + HALF;
            rot_neg = 1'b1;
        end
        else
        begin
            rot_zf  = rot_z;
            rot_neg = 1'b0;
        end

        dx_neg = dx_reg[COORD_W];
        vx17   = dx_neg ? -dx_reg : dx_reg;
        vy17   = dx_neg ? -dy_reg : dy_reg;

        cmd.start = 1'b0;
        cmd.mode  = MODE_ROTATE;
        cmd.x     = gain_reg;
        cmd.y     = '0;
        cmd.z     = rot_zf;
        div_start = 1'b0;

        state_next     = state_reg;
        func_next      = func_reg;
        n_next         = n_reg;
        dvs_next       = dvs_reg;
        idx_next       = idx_reg;
        num_next       = num_reg;
        base_next      = base_reg;
        arc_next       = arc_reg;
        speed_next     = speed_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        gain_next      = gain_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !m_tready;
        vel_x_next     = vel_x_reg;
        vel_y_next     = vel_y_reg;
        shot_out_next  = shot_out_reg;
        last_out_next  = last_out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next  = s_tuser[0];
                    n_next     = count_in;
                    dvs_next   = s_tuser[0] ? (count_in - 1'b1) : count_in;
                    base_next  = first_ang_in;
                    arc_next   = arc_in;
                    speed_next = shot_speed;
                    dx_next    = signed'({aim_x[COORD_W-1], aim_x})
                               - signed'({source_x[COORD_W-1], source_x});
                    dy_next    = signed'({aim_y[COORD_W-1], aim_y})
                               - signed'({source_y[COORD_W-1], source_y});
                    idx_next   = '0;
                    num_next   = '0;
                    if (count_in != '0)
                    begin
                        state_next = S_SETUP;
                    end
                end
            end

            S_SETUP:
            begin
                gain_next = signed'(DP_W'(gain_prod >> 7));
                if (!func_reg)
                begin
                    state_next = S_BASE;
                end
                else if (dx_reg == '0 && dy_reg == '0)
                begin
                    // Source on the aim point: the fan is centred on angle zero.
                    base_next  = (n_reg == COUNT_W'(1)) ? '0 : ('0 - (arc_reg >> 1));
                    state_next = S_BASE;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.mode   = MODE_VECTOR;
                    cmd.x      = DP_W'(vx17) <<< WORK_FRAC;
                    cmd.y      = DP_W'(vy17) <<< WORK_FRAC;
                    cmd.z      = dx_neg ? HALF : '0;
                    state_next = S_VEC;
                end
            end

            S_VEC:
            begin
                if (res.done)
                begin
                    base_next  = (n_reg == COUNT_W'(1)) ? centre : (centre - (arc_reg >> 1));
                    state_next = S_BASE;
                end
            end

            S_BASE:
            begin
                cmd.start  = 1'b1;
                neg_next   = rot_neg;
                state_next = S_ROT;
            end

            S_ROT:
            begin
                if (res.done)
                begin
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    vel_x_next     = sat_vel(res.x, neg_reg);
                    vel_y_next     = sat_vel(res.y, neg_reg);
                    shot_out_next  = idx_reg;
                    last_out_next  = is_last;
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        num_next   = num_sum;
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    cmd.start  = 1'b1;
                    neg_next   = rot_neg;
                    state_next = S_ROT;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        n_reg        <= n_next;
        dvs_reg      <= dvs_next;
        idx_reg      <= idx_next;
        num_reg      <= num_next;
        base_reg     <= base_next;
        arc_reg      <= arc_next;
        speed_reg    <= speed_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        gain_reg     <= gain_next;
        neg_reg      <= neg_next;
        vel_x_reg    <= vel_x_next;
        vel_y_reg    <= vel_y_next;
        shot_out_reg <= shot_out_next;
        last_out_reg <= last_out_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, shot_out_reg, vel_y_reg, vel_x_reg};
    assign m_tlast  = last_out_reg;

endmodule

/* rtl/rafvg_checker.sv */
// ----------------------------------------------------------------------------
// rafvg_checker
// Port-level checks of the ring and fan vector generator, bound to the top.
// ----------------------------------------------------------------------------
module rafvg_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [rafvg_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [rafvg_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                             m_tlast
);

    // A burst in progress never lets a new request in.
    a_busy_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request accepted while a burst is still being delivered");

    // A request with a non-zero count occupies the block.
    a_request_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[7:0] != 8'd0) |=> !s_tready)
        else $error("block still ready after taking a non-empty request");

    // A request with a zero count produces nothing and leaves the block ready.
    a_empty_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[7:0] == 8'd0) |=> s_tready)
        else $error("empty request made the block busy");

    // Once the final beat of a burst is taken there is nothing more to send.
    a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("beat offered straight after the end of a burst");

    // A stalled output beat holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output beat changed");

endmodule

bind ring_and_fan_vector_generator rafvg_checker u_rafvg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* verif/shot_burst_checker.sv */
// ----------------------------------------------------------------------------
// shot_burst_checker
// Watches the request and vector channels of the ring and fan vector
// generator. It works out every vector that an accepted request should give
// and compares each vector beat, field by field, with the oldest one owed.
// ----------------------------------------------------------------------------
module shot_burst_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [rafvg_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [0:0]                       s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [rafvg_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                             m_tlast,
    output int                               fail_count,
    output int                               pending,
    output int                               vectors_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import rafvg_pkg::*;

    localparam int SHOT_CAP  = MAX_SHOTS_DEF;
    localparam int ANG_W     = ANGLE_BITS_DEF;
    localparam int ROT_STEPS = (CORDIC_STEPS_DEF > TABLE_LEN) ? TABLE_LEN :
                               ((CORDIC_STEPS_DEF < 1) ? 1 : CORDIC_STEPS_DEF);
    localparam int TURN_SHIFT = 32 - ANG_W;

    localparam longint ANG_MASK = (64'sd1 <<< ANG_W) - 64'sd1;
    localparam longint LOW32    = 64'sh0000_0000_FFFF_FFFF;
    localparam longint QUARTER  = 64'sh0000_0000_4000_0000;
    localparam longint HALF     = 64'sh0000_0000_8000_0000;
    localparam longint FULL     = 64'sh0000_0001_0000_0000;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic [SHOT_W-1:0]       number;
        logic                    last;
    } shot_vec_t;

    shot_vec_t expected_shots[$];
    int        errors = 0;
    int        vectors_seen = 0;

    // Arctangent of 2^-i in 2^32 units per turn.
    function automatic longint arctan_turn(input int i);
        case (i)
            0:       return 64'sh20000000;
            1:       return 64'sh12E4051E;
            2:       return 64'sh09FB385B;
            3:       return 64'sh051111D4;
            4:       return 64'sh028B0D43;
            5:       return 64'sh0145D7E1;
            6:       return 64'sh00A2F61E;
            7:       return 64'sh00517C55;
            8:       return 64'sh0028BE53;
            9:       return 64'sh00145F2F;
            10:      return 64'sh000A2F98;
            11:      return 64'sh000517CC;
            12:      return 64'sh00028BE6;
            13:      return 64'sh000145F3;
            14:      return 64'sh0000A2FA;
            15:      return 64'sh0000517D;
            16:      return 64'sh000028BE;
            17:      return 64'sh0000145F;
            18:      return 64'sh00000A30;
            19:      return 64'sh00000518;
            20:      return 64'sh0000028C;
            21:      return 64'sh00000146;
            22:      return 64'sh000000A3;
            23:      return 64'sh00000051;
            default: return 64'sh0;
        endcase
    endfunction

    function automatic longint widen_angle(input longint v);
        if (ANG_W >= 16)
        begin
            return (v & 64'shFFFF) << (ANG_W - 16);
        end
        return (v & 64'shFFFF) >> (16 - ANG_W);
    endfunction

    function automatic longint round_sat(input longint v);
        longint r;
        r = (v + (64'sd1 <<< (WORK_FRAC - 1))) >>> WORK_FRAC;
        if (r > VEL_LIMIT)
        begin
            r = VEL_LIMIT;
        end
        if (r < -VEL_LIMIT)
        begin
            r = -VEL_LIMIT;
        end
        return r;
    endfunction

    // Vectoring pass: angle of (dx, dy), rounded half up to the angle width.
    function automatic longint aim_direction(input longint dx, input longint dy);
        longint x;
        longint y;
        longint xs;
        longint ys;
        longint acc;
        int     i;
        acc = 0;
        if (dx == 0 && dy == 0)
        begin
            return 0;
        end
        if (dx < 0)
        begin
            dx  = -dx;
            dy  = -dy;
            acc = HALF;
        end
        x = dx <<< WORK_FRAC;
        y = dy <<< WORK_FRAC;
        for (i = 0; i < ROT_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x   = x + ys;
                y   = y - xs;
                acc = acc + arctan_turn(i);
            end
            else if (y < 0)
            begin
                x   = x - ys;
                y   = y + xs;
                acc = acc - arctan_turn(i);
            end
        end
        acc = acc & LOW32;
        if (TURN_SHIFT > 0)
        begin
            acc = (acc + (64'sd1 <<< (TURN_SHIFT - 1))) >> TURN_SHIFT;
        end
        return acc & ANG_MASK;
    endfunction

    // Rotation pass: the gain-corrected speed turned to the given angle.
    task automatic spin_vector(input longint ang, input longint speed,
                               output longint vx, output longint vy);
        longint z;
        longint kq;
        longint x;
        longint y;
        longint xs;
        longint ys;
        logic   flip;
        int     i;
        flip = 1'b0;
        z = ((ang & ANG_MASK) << TURN_SHIFT) & LOW32;
        if (z >= HALF)
        begin
            z = z - FULL;
        end
        // Fold the left half plane onto the right and negate at the end.
        if (z > QUARTER)
        begin
            z    = z - HALF;
            flip = 1'b1;
        end
        else if (z < -QUARTER)
        begin
            z    = z + HALF;
            flip = 1'b1;
        end
        kq = INV_GAIN_Q31 + (INV_GAIN_Q31 >>> (2 * ROT_STEPS - 1)) / 3;
        x  = (speed * kq) >>> 7;
        y  = 0;
        for (i = 0; i < ROT_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_turn(i);
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_turn(i);
            end
        end
        vx = round_sat(x);
        vy = round_sat(y);
        if (flip)
        begin
            vx = -vx;
            vy = -vy;
        end
    endtask

    task automatic queue_shot(input longint ang, input longint speed,
                              input longint idx, input logic last);
        longint    vx;
        longint    vy;
        shot_vec_t v;
        spin_vector(ang, speed, vx, vy);
        v.vel_x  = vx[VEL_W-1:0];
        v.vel_y  = vy[VEL_W-1:0];
        v.number = idx[SHOT_W-1:0];
        v.last   = last;
        expected_shots.push_back(v);
    endtask

    task automatic predict_burst(input logic fan, input logic [7:0] cnt,
                                 input logic [15:0] first, input logic [15:0] speed,
                                 input logic [15:0] sx, input logic [15:0] sy,
                                 input logic [15:0] ax, input logic [15:0] ay,
                                 input logic [15:0] arc);
        longint n;
        longint i;
        longint start;
        longint centre;
        longint span;
        longint d;
        longint ang;
        n = longint'(cnt);
        if (n > SHOT_CAP)
        begin
            n = SHOT_CAP;
        end
        if (n > RESULT_LIMIT)
        begin
            n = RESULT_LIMIT;
        end
        if (n == 0)
        begin
            return;
        end
        start  = widen_angle(longint'(first));
        centre = 0;
        span   = 0;
        if (fan)
        begin
            centre = aim_direction(longint'($signed(ax)) - longint'($signed(sx)),
                                   longint'($signed(ay)) - longint'($signed(sy)));
            span   = widen_angle(longint'(arc));
        end
        if (fan && n == 1)
        begin
            queue_shot(centre, longint'(speed), 0, 1'b1);
        end
        else
        begin
            for (i = 0; i < n; i++)
            begin
                if (fan)
                begin
                    d   = n - 1;
                    ang = (centre - (span >> 1) + (span * i + d / 2) / d) & ANG_MASK;
                end
                else
                begin
                    ang = (start + (((i << ANG_W) + n / 2) / n)) & ANG_MASK;
                end
                queue_shot(ang, longint'(speed), i, (i + 1) == n);
            end
        end
    endtask

    task automatic flag_field(input string field, input logic signed [VEL_W-1:0] want_v,
                              input logic signed [VEL_W-1:0] got_v);
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    endtask

    always @(posedge clk)
    begin : watch
        shot_vec_t seen;
        shot_vec_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen.vel_x  = m_tdata[VEL_W-1:0];
                seen.vel_y  = m_tdata[2*VEL_W-1:VEL_W];
                seen.number = m_tdata[2*VEL_W+SHOT_W-1:2*VEL_W];
                seen.last   = m_tlast;
                vectors_seen++;
                if (expected_shots.size() == 0)
                begin
                    errors++;
                    $display("%0t: unowed vector beat, expected nothing, got %0d %0d %0d %0d",
                             $time, seen.vel_x, seen.vel_y, seen.number, seen.last);
                end
                else
                begin
                    want = expected_shots.pop_front();
                    if (seen.vel_x !== want.vel_x)
                    begin
                        flag_field("vel_x", want.vel_x, seen.vel_x);
                    end
                    if (seen.vel_y !== want.vel_y)
                    begin
                        flag_field("vel_y", want.vel_y, seen.vel_y);
                    end
                    if (seen.number !== want.number)
                    begin
                        flag_field("shot_number", VEL_W'(want.number), VEL_W'(seen.number));
                    end
                    if (seen.last !== want.last)
                    begin
                        flag_field("last_shot", VEL_W'(want.last), VEL_W'(seen.last));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_burst(s_tuser[0], s_tdata[7:0], s_tdata[23:8], s_tdata[39:24],
                              s_tdata[55:40], s_tdata[71:56], s_tdata[87:72],
                              s_tdata[103:88], s_tdata[119:104]);
            end
        end
        fail_count      <= errors;
        pending         <= expected_shots.size();
        vectors_checked <= vectors_seen;
    end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Top of the ring and fan vector generator testbench. Drives directed and
// random ring and fan requests with random gaps on both channels, and leaves
// prediction and checking to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rafvg_pkg::*;

    localparam int RANDOM_REQUESTS = 430;
    localparam int TAIL_CYCLES     = 1500;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    int fail_count;
    int pending;
    int vectors_checked;
    int ring_requests = 0;
    int fan_requests = 0;
    bit src_idle_on = 1'b1;
    bit sink_idle_on = 1'b1;

    ring_and_fan_vector_generator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    shot_burst_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .pending         (pending),
        .vectors_checked (vectors_checked)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Hands one request beat over, after a random gap while gaps are on, and waits for it to go.
    task automatic send_request(input logic fan, input logic [7:0] cnt,
                                input logic [15:0] first, input logic [15:0] speed,
                                input logic [15:0] sx, input logic [15:0] sy,
                                input logic [15:0] ax, input logic [15:0] ay,
                                input logic [15:0] arc);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {arc, ay, ax, sy, sx, speed, first, cnt};
        s_tuser  <= fan;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (fan)
        begin
            fan_requests++;
        end
        else
        begin
            ring_requests++;
        end
    endtask

    task automatic random_request();
        logic        fan;
        logic [7:0]  cnt;
        logic [15:0] speed;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] ax;
        logic [15:0] ay;
        logic [15:0] arc;
        int          pick;
        fan  = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        // Mostly short bursts; full bursts are slow and kept to a few.
        if (pick < 10)
        begin
            cnt = 8'd0;
        end
        else if (pick < 72)
        begin
            cnt = 8'($urandom_range(1, 8));
        end
        else if (pick < 92)
        begin
            cnt = 8'($urandom_range(9, 32));
        end
        else
        begin
            cnt = 8'($urandom_range(33, 255));
        end
        pick = $urandom_range(0, 99);
        speed = (pick < 5) ? 16'hFFFF : ((pick < 8) ? 16'h0000 : 16'($urandom));
        sx = 16'($urandom);
        sy = 16'($urandom);
        ax = 16'($urandom);
        ay = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            ax = sx;
            ay = sy;
        end
        else if (pick < 25)
        begin
            ax = sx + 16'($urandom_range(0, 16)) - 16'd8;
            ay = sy + 16'($urandom_range(0, 16)) - 16'd8;
        end
        pick = $urandom_range(0, 99);
        arc = (pick < 8) ? 16'h0000 : ((pick < 14) ? 16'hFFFF : 16'($urandom));
        send_request(fan, cnt, 16'($urandom), speed, sx, sy, ax, ay, arc);
    endtask

    initial
    begin : sink
        int gap;
        m_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            gap = sink_idle_on ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin : stimulus
        int k;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Ring mode: quadrant edges, saturation, clamping and an empty burst.
        send_request(1'b0, 8'd1,   16'h0000, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(1'b0, 8'd1,   16'h4000, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(1'b0, 8'd1,   16'h4001, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(1'b0, 8'd1,   16'h8000, 16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(1'b0, 8'd1,   16'hC000, 16'h0080, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(1'b0, 8'd4,   16'hFFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(1'b0, 8'd32,  16'h2000, 16'h1234, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(1'b0, 8'd255, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF);
        send_request(1'b0, 8'd0,   16'h1234, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(1'b0, 8'd33,  16'h1111, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_request(1'b0, 8'd3,   16'h5555, 16'hAAAA, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);

        // Fan mode: source on the aim point, single vector, extreme deltas and
        // aim directions along three axes and into three of the four quadrants.
        send_request(1'b1, 8'd1,   16'h0, 16'h0100, 16'h1234, 16'h5678, 16'h1234, 16'h5678,
                     16'h4000);
        send_request(1'b1, 8'd5,   16'h0, 16'h0100, 16'h1234, 16'h5678, 16'h1234, 16'h5678,
                     16'hFFFF);
        send_request(1'b1, 8'd2,   16'h0, 16'h0200, 16'h0000, 16'h0000, 16'h0010, 16'h0010,
                     16'h0000);
        send_request(1'b1, 8'd7,   16'h0, 16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF,
                     16'h8000);
        send_request(1'b1, 8'd6,   16'h0, 16'h0300, 16'h7FFF, 16'h0000, 16'h8000, 16'h0000,
                     16'h2000);
        send_request(1'b1, 8'd3,   16'h0, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0064,
                     16'h1000);
        send_request(1'b1, 8'd3,   16'h0, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'hFF9C,
                     16'h1000);
        send_request(1'b1, 8'd4,   16'h0, 16'h0400, 16'h0100, 16'h0100, 16'hFF00, 16'hFE00,
                     16'hFFFF);
        send_request(1'b1, 8'd32,  16'h0, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                     16'hFFFF);
        send_request(1'b1, 8'd0,   16'h0, 16'h0100, 16'h0100, 16'h0200, 16'h0300, 16'h0400,
                     16'h1000);
        send_request(1'b1, 8'd200, 16'h0, 16'h0180, 16'hF123, 16'h0456, 16'h3789, 16'hCABC,
                     16'h0001);
        send_request(1'b1, 8'd1,   16'h0, 16'hFFFF, 16'h4000, 16'hC000, 16'h4000, 16'hC000,
                     16'h0000);

        for (k = 0; k < RANDOM_REQUESTS; k++)
        begin
            // Switch gaps on and off per side so that stretches run flat out.
            if (k % 40 == 0)
            begin
                src_idle_on  = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
            end
            random_request();
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d ring and %0d fan requests and checked %0d vectors,",
                 ring_requests, fan_requests, vectors_checked);
        $display("with random gaps on both channels switched on and off in stretches.");
        if (fail_count == 0 && pending == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(60_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
